// ===== rtl/dcle_pkg.sv =====
package dcle_pkg;

	// Input item kinds, carried on s_tuser.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_HEADER = 2'd1;
	localparam logic [1:0] OP_OPTION = 2'd2;
	localparam logic [1:0] OP_END    = 2'd3;

	// Result kinds, carried on m_tuser.
	localparam logic [1:0] ACT_SEND_DISCOVER = 2'd0;
	localparam logic [1:0] ACT_SEND_REQUEST  = 2'd1;
	localparam logic [1:0] ACT_LEASE_ACQ     = 2'd2;
	localparam logic [1:0] ACT_LEASE_EXP     = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_XID          = 2'd0;
	localparam logic [1:0] REG_DISCOVER_RTY = 2'd1;
	localparam logic [1:0] REG_REQUEST_RTY  = 2'd2;
	localparam logic [1:0] REG_LEASE        = 2'd3;

	localparam logic [15:0] DISCOVER_RTY_RST = 16'd5000;
	localparam logic [15:0] REQUEST_RTY_RST  = 16'd2000;
	localparam logic [23:0] LEASE_RST        = 24'd300000;

	// Client phases.
	localparam logic [1:0] PH_DISCOVER = 2'd0;
	localparam logic [1:0] PH_REQUEST  = 2'd1;
	localparam logic [1:0] PH_BOUND    = 2'd2;

	// Option parser phases.
	localparam logic [1:0] PP_CODE  = 2'd0;
	localparam logic [1:0] PP_LEN   = 2'd1;
	localparam logic [1:0] PP_VALUE = 2'd2;
	localparam logic [1:0] PP_DONE  = 2'd3;

	localparam logic [7:0] OPT_ROUTER   = 8'd3;
	localparam logic [7:0] OPT_DNS      = 8'd6;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_END      = 8'd255;
	localparam logic [7:0] LEN_TYPE     = 8'd1;
	localparam logic [7:0] LEN_ADDR     = 8'd4;

	localparam logic [7:0] MSG_OFFER   = 8'd2;
	localparam logic [7:0] MSG_ACK     = 8'd5;
	localparam logic [7:0] BOOTP_REPLY = 8'd2;

	localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

endpackage

// ===== rtl/dhcp_client_lease_engine.sv =====
// A request's result, if any, is written to the result register when the request leaves
// the input register; the update logic between the two registers is combinational.
// Throughput: one request per cycle unless stalled; the single update stage applies ticks,
// header, option bytes and reply end to the lease state in the cycle they leave the input
// register. A request that produces a result waits in the input register while the result
// register still holds a result that has not been taken, and the input stalls behind it.
// Reset (arst_n low, asynchronous) puts the client in the discover phase with a send
// pending, clears all addresses and restores the default retry and lease intervals.
module dhcp_client_lease_engine #(
	parameter int OPTION_AREA_BYTES = 312
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0 up: reply_xid[31:0], reply_kind[7:0], your_address[31:0],
	// server_address[31:0], option_byte[7:0].
	input  logic [111:0] s_tdata,
	// Fields from bit 0 up: opcode[1:0].
	input  logic [1:0]   s_tuser,
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0 up: xid_out[31:0], requested_address[31:0],
	// server_identifier[31:0], router_address[31:0], dns_address[31:0].
	output logic [159:0] m_tdata,
	// Fields from bit 0 up: action[1:0].
	output logic [1:0]   m_tuser,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// The parse position has to be able to hold the full area size itself.
	localparam int PosW = $clog2(OPTION_AREA_BYTES + 1);

	// Configuration registers.
	logic [31:0] xid_q;
	logic [15:0] disc_rty_q;
	logic [15:0] req_rty_q;
	logic [23:0] lease_q;

	// Input register. The payload is held without reset; only the valid bit is control.
	logic         valid_s1;
	logic [1:0]   opcode_s1;
	logic [111:0] data_s1;

	// Field views of the registered request.
	logic [31:0] in_xid;
	logic [7:0]  in_kind;
	logic [31:0] in_your;
	logic [31:0] in_server;
	logic [7:0]  in_byte;

	assign in_xid    = data_s1[31:0];
	assign in_kind   = data_s1[39:32];
	assign in_your   = data_s1[71:40];
	assign in_server = data_s1[103:72];
	assign in_byte   = data_s1[111:104];

	// Lease state.
	logic [1:0]  phase_q;
	logic [23:0] elapsed_q;
	logic        send_now_q;
	logic [31:0] client_q;
	logic [31:0] server_id_q;
	logic [31:0] gateway_q;
	logic [31:0] dns_q;

	// Latched reply header.
	logic        hdr_valid_q;
	logic [31:0] hdr_your_q;
	logic [31:0] hdr_server_q;

	// Option parser state.
	logic [PosW-1:0] pos_q;
	logic [1:0]      pp_q;
	logic [7:0]      opt_code_q;
	logic [7:0]      opt_len_q;
	logic [7:0]      opt_rem_q;
	logic [31:0]     acc_q;
	logic            type_found_q;
	logic [7:0]      type_value_q;
	logic            router_seen_q;
	logic            dns_seen_q;
	logic [31:0]     router_cand_q;
	logic [31:0]     dns_cand_q;

	// Next-state values.
	logic [1:0]      phase_n;
	logic [23:0]     elapsed_n;
	logic            send_now_n;
	logic [31:0]     client_n;
	logic [31:0]     server_id_n;
	logic [31:0]     gateway_n;
	logic [31:0]     dns_n;
	logic            hdr_valid_n;
	logic [31:0]     hdr_your_n;
	logic [31:0]     hdr_server_n;
	logic [PosW-1:0] pos_n;
	logic [1:0]      pp_n;
	logic [7:0]      opt_code_n;
	logic [7:0]      opt_len_n;
	logic [7:0]      opt_rem_n;
	logic [31:0]     acc_n;
	logic            type_found_n;
	logic [7:0]      type_value_n;
	logic            router_seen_n;
	logic            dns_seen_n;
	logic [31:0]     router_cand_n;
	logic [31:0]     dns_cand_n;

	logic        emit;
	logic [1:0]  action_n;
	logic [23:0] elapsed_inc;
	logic        advance;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  action_q;
	logic [159:0] out_data_q;

	// The registered request moves on unless it produces a result and the result
	// register is still occupied. Requests that produce nothing never wait.
	assign advance  = valid_s1 && (!out_valid_q || m_tready || !emit);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = action_q;
	assign m_tdata  = out_data_q;

	assign elapsed_inc = (elapsed_q == dcle_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 24'd1;

	always_comb begin
		phase_n       = phase_q;
		elapsed_n     = elapsed_q;
		send_now_n    = send_now_q;
		client_n      = client_q;
		server_id_n   = server_id_q;
		gateway_n     = gateway_q;
		dns_n         = dns_q;
		hdr_valid_n   = hdr_valid_q;
		hdr_your_n    = hdr_your_q;
		hdr_server_n  = hdr_server_q;
		pos_n         = pos_q;
		pp_n          = pp_q;
		opt_code_n    = opt_code_q;
		opt_len_n     = opt_len_q;
		opt_rem_n     = opt_rem_q;
		acc_n         = acc_q;
		type_found_n  = type_found_q;
		type_value_n  = type_value_q;
		router_seen_n = router_seen_q;
		dns_seen_n    = dns_seen_q;
		router_cand_n = router_cand_q;
		dns_cand_n    = dns_cand_q;
		emit          = 1'b0;
		action_n      = dcle_pkg::ACT_SEND_DISCOVER;

		case (opcode_s1)
			dcle_pkg::OP_TICK: begin
				// The counter advances first; a send restarts it, an expiry leaves it.
				elapsed_n = elapsed_inc;
				case (phase_q)
					dcle_pkg::PH_DISCOVER: begin
						if (send_now_q || elapsed_inc > {8'd0, disc_rty_q}) begin
							send_now_n = 1'b0;
							elapsed_n  = '0;
							emit       = 1'b1;
							action_n   = dcle_pkg::ACT_SEND_DISCOVER;
						end
					end
					dcle_pkg::PH_REQUEST: begin
						if (send_now_q || elapsed_inc > {8'd0, req_rty_q}) begin
							send_now_n = 1'b0;
							elapsed_n  = '0;
							emit       = 1'b1;
							action_n   = dcle_pkg::ACT_SEND_REQUEST;
						end
					end
					dcle_pkg::PH_BOUND: begin
						if (elapsed_inc > lease_q) begin
							phase_n    = dcle_pkg::PH_DISCOVER;
							send_now_n = 1'b1;
							client_n   = '0;
							emit       = 1'b1;
							action_n   = dcle_pkg::ACT_LEASE_EXP;
						end
					end
					default: begin
					end
				endcase
			end
			dcle_pkg::OP_HEADER: begin
				// A new header always restarts the parser, even mid-reply.
				hdr_your_n    = in_your;
				hdr_server_n  = in_server;
				hdr_valid_n   = (in_xid == xid_q) && (in_kind == dcle_pkg::BOOTP_REPLY);
				pos_n         = '0;
				pp_n          = dcle_pkg::PP_CODE;
				opt_code_n    = '0;
				opt_len_n     = '0;
				opt_rem_n     = '0;
				acc_n         = '0;
				type_found_n  = 1'b0;
				type_value_n  = '0;
				router_seen_n = 1'b0;
				dns_seen_n    = 1'b0;
				router_cand_n = '0;
				dns_cand_n    = '0;
			end
			dcle_pkg::OP_OPTION: begin
				// Bytes after the end option or past the option area are dropped.
				if (pp_q != dcle_pkg::PP_DONE && pos_q < PosW'(OPTION_AREA_BYTES)) begin
					pos_n = pos_q + PosW'(1);
					case (pp_q)
						dcle_pkg::PP_CODE: begin
							if (in_byte == dcle_pkg::OPT_END) begin
								pp_n = dcle_pkg::PP_DONE;
							end else begin
								opt_code_n = in_byte;
								pp_n       = dcle_pkg::PP_LEN;
							end
						end
						dcle_pkg::PP_LEN: begin
							opt_len_n = in_byte;
							opt_rem_n = in_byte;
							acc_n     = '0;
							pp_n      = (in_byte == 8'd0) ? dcle_pkg::PP_CODE : dcle_pkg::PP_VALUE;
						end
						dcle_pkg::PP_VALUE: begin
							acc_n     = {acc_q[23:0], in_byte};
							opt_rem_n = opt_rem_q - 8'd1;
							if (opt_rem_q == 8'd1) begin
								// Only the first message type counts; later address
								// options replace earlier ones.
								if (opt_code_q == dcle_pkg::OPT_MSG_TYPE &&
								    opt_len_q == dcle_pkg::LEN_TYPE && !type_found_q) begin
									type_found_n = 1'b1;
									type_value_n = in_byte;
								end else if (opt_code_q == dcle_pkg::OPT_ROUTER &&
								             opt_len_q == dcle_pkg::LEN_ADDR) begin
									router_seen_n = 1'b1;
									router_cand_n = {acc_q[23:0], in_byte};
								end else if (opt_code_q == dcle_pkg::OPT_DNS &&
								             opt_len_q == dcle_pkg::LEN_ADDR) begin
									dns_seen_n = 1'b1;
									dns_cand_n = {acc_q[23:0], in_byte};
								end
								pp_n = dcle_pkg::PP_CODE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			dcle_pkg::OP_END: begin
				// The reply is judged once; the parser then waits for the next header.
				hdr_valid_n = 1'b0;
				pp_n        = dcle_pkg::PP_DONE;
				if (hdr_valid_q && type_found_q) begin
					if (type_value_q == dcle_pkg::MSG_OFFER && phase_q == dcle_pkg::PH_DISCOVER) begin
						if (hdr_your_q != 32'd0) begin
							client_n    = hdr_your_q;
							server_id_n = hdr_server_q;
							phase_n     = dcle_pkg::PH_REQUEST;
							send_now_n  = 1'b1;
						end
					end else if (type_value_q == dcle_pkg::MSG_ACK &&
					             phase_q == dcle_pkg::PH_REQUEST) begin
						if (hdr_your_q == client_q) begin
							if (router_seen_q) begin
								gateway_n = router_cand_q;
							end
							if (dns_seen_q) begin
								dns_n = dns_cand_q;
							end
							phase_n  = dcle_pkg::PH_BOUND;
							emit     = 1'b1;
							action_n = dcle_pkg::ACT_LEASE_ACQ;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control and lease state, configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q         <= '0;
			disc_rty_q    <= dcle_pkg::DISCOVER_RTY_RST;
			req_rty_q     <= dcle_pkg::REQUEST_RTY_RST;
			lease_q       <= dcle_pkg::LEASE_RST;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			action_q      <= dcle_pkg::ACT_SEND_DISCOVER;
			phase_q       <= dcle_pkg::PH_DISCOVER;
			elapsed_q     <= '0;
			send_now_q    <= 1'b1;
			client_q      <= '0;
			server_id_q   <= '0;
			gateway_q     <= '0;
			dns_q         <= '0;
			hdr_valid_q   <= 1'b0;
			hdr_your_q    <= '0;
			hdr_server_q  <= '0;
			pos_q         <= '0;
			pp_q          <= dcle_pkg::PP_CODE;
			opt_code_q    <= '0;
			opt_len_q     <= '0;
			opt_rem_q     <= '0;
			acc_q         <= '0;
			type_found_q  <= 1'b0;
			type_value_q  <= '0;
			router_seen_q <= 1'b0;
			dns_seen_q    <= 1'b0;
			router_cand_q <= '0;
			dns_cand_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dcle_pkg::REG_XID:          xid_q      <= cfg_data;
					dcle_pkg::REG_DISCOVER_RTY: disc_rty_q <= cfg_data[15:0];
					dcle_pkg::REG_REQUEST_RTY:  req_rty_q  <= cfg_data[15:0];
					dcle_pkg::REG_LEASE:        lease_q    <= cfg_data[23:0];
					default: begin
					end
				endcase
			end

			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end

			if (advance && emit) begin
				out_valid_q <= 1'b1;
				action_q    <= action_n;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (advance) begin
				phase_q       <= phase_n;
				elapsed_q     <= elapsed_n;
				send_now_q    <= send_now_n;
				client_q      <= client_n;
				server_id_q   <= server_id_n;
				gateway_q     <= gateway_n;
				dns_q         <= dns_n;
				hdr_valid_q   <= hdr_valid_n;
				hdr_your_q    <= hdr_your_n;
				hdr_server_q  <= hdr_server_n;
				pos_q         <= pos_n;
				pp_q          <= pp_n;
				opt_code_q    <= opt_code_n;
				opt_len_q     <= opt_len_n;
				opt_rem_q     <= opt_rem_n;
				acc_q         <= acc_n;
				type_found_q  <= type_found_n;
				type_value_q  <= type_value_n;
				router_seen_q <= router_seen_n;
				dns_seen_q    <= dns_seen_n;
				router_cand_q <= router_cand_n;
				dns_cand_q    <= dns_cand_n;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1 <= s_tuser;
			data_s1   <= s_tdata;
		end
		if (advance && emit) begin
			// A result reports the state as it stands after this request.
			out_data_q <= {dns_n, gateway_n, server_id_n, client_n, xid_q};
		end
	end

`ifndef ASSERT_OFF
	// An expiry result never carries a client address.
	a_expiry_clears_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == dcle_pkg::ACT_LEASE_EXP) |-> (m_tdata[63:32] == 32'd0))
		else $error("lease expiry reported with a nonzero address");

	// A reply end always invalidates the latched header.
	a_end_drops_header: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && opcode_s1 == dcle_pkg::OP_END) |=> !hdr_valid_q)
		else $error("header still valid after reply end");

	// Sending a discover or request restarts the retry timer.
	a_send_restarts_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && opcode_s1 == dcle_pkg::OP_TICK &&
		 (action_n == dcle_pkg::ACT_SEND_DISCOVER || action_n == dcle_pkg::ACT_SEND_REQUEST))
		|=> (elapsed_q == 24'd0))
		else $error("retry timer not restarted after a send");

	// The parser never walks past the option area.
	a_pos_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosW'(OPTION_AREA_BYTES))
		else $error("option parse position beyond the option area");

	// A lease is only reported acquired on entry to the bound phase.
	a_acquire_binds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && action_n == dcle_pkg::ACT_LEASE_ACQ)
		|=> (phase_q == dcle_pkg::PH_BOUND))
		else $error("lease acquired without entering the bound phase");
`endif

endmodule
